// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sector walker.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in sector walker");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in sector walker");

`endif

// ----- hw/rtl/fsw_pkg.sv -----
// Shared types, constants and helper functions of the FAT12 sector walker.
// Used by every module of the block; depends on nothing.
package fsw_pkg;

  localparam int FAT_BYTES    = 8192;
  localparam int FAT_AW       = $clog2(FAT_BYTES);
  localparam int SECTOR_BYTES = 512;
  localparam int CHUNK_W      = 10;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [11:0] LINK_MASK   = 12'h fff;
  localparam logic [11:0] LINK_BAD    = 12'h ff7;
  localparam logic [11:0] LINK_EOC    = 12'h ff8;
  localparam logic [7:0]  NIBBLE_MASK = 8'h 0f;

  localparam logic [15:0] DATA_START_RESET = 16'd33;
  localparam logic [7:0]  SPC_RESET        = 8'd1;
  localparam logic [11:0] CCOUNT_RESET     = 12'd2847;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_DATA_START = 2'd0,
    REG_SPC        = 2'd1,
    REG_CCOUNT     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_BAD_START   = 3'd2,
    ST_BAD_CLUSTER = 3'd3,
    ST_EARLY_END   = 3'd4,
    ST_RANGE       = 3'd5,
    ST_IDLE        = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_START,
    CMD_STEP,
    CMD_NOP
  } cmd_kind_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [12:0] addr;
    logic [7:0]  data;
    logic [11:0] cluster;
    logic [15:0] len;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SECT,
    B_LINK,
    B_EMIT
  } back_state_t;

  // A cluster is valid when it lies in 2 .. count+1.
  function automatic logic cluster_ok(input logic [11:0] c, input logic [11:0] count);
    cluster_ok = (c >= 12'd2) && ({1'b0, c} < ({1'b0, count} + 13'd2));
  endfunction

endpackage

// ----- hw/rtl/fsw_front.sv -----
// Front end of the sector walker: decodes an input word and clamps the file length.
// Depends on fsw_pkg.
module fsw_front import fsw_pkg::*; (
  input  logic [1:0]  opcode,
  input  logic [12:0] fat_address,
  input  logic [7:0]  fat_byte,
  input  logic [11:0] start_cluster,
  input  logic [31:0] file_size,
  input  logic [15:0] max_bytes,
  output cmd_t        cmd
);

  always_comb begin
    cmd.addr    = fat_address;
    cmd.data    = fat_byte;
    cmd.cluster = start_cluster;
    // The byte count is the smaller of the file size and the buffer limit.
    if (file_size > {16'd0, max_bytes}) begin
      cmd.len = max_bytes;
    end else begin
      cmd.len = file_size[15:0];
    end
    unique case (opcode)
      OP_WRITE: cmd.kind = CMD_WRITE;
      OP_START: cmd.kind = CMD_START;
      OP_STEP:  cmd.kind = CMD_STEP;
      default:  cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/fsw_queue.sv -----
// Short command queue between the front and back of the sector walker.
// Depends on fsw_pkg for the command type and depth.
module fsw_queue import fsw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic nonempty,
  output logic full
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign nonempty = (count != '0);
  assign full     = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/fsw_back.sv -----
// Back end of the sector walker: FAT store, walk state, chain following and result word.
// Depends on fsw_pkg.
module fsw_back import fsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sector,
  output logic [9:0]  out_chunk,
  output logic [15:0] out_offset,
  output logic        out_last,
  output status_t     out_status
);

  // Configuration.
  logic [15:0] data_start;
  logic [7:0]  spc;
  logic [11:0] ccount;

  // Walk state.
  back_state_t state, state_next;
  logic        active, active_next;
  logic [11:0] cur, cur_next;
  logic [7:0]  sic, sic_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] woff, woff_next;

  // Per-step scratch registers.
  logic [15:0] prod, prod_next;
  logic [7:0]  sic_old, sic_old_next;
  logic [9:0]  chunk, chunk_next;
  logic [15:0] offs, offs_next;
  logic        need_link, need_link_next;
  logic        done, done_next;
  logic [13:0] pos, pos_next;
  logic        link_oob, link_oob_next;
  logic [7:0]  b0, b0_next;
  logic [15:0] res_sector, res_sector_next;
  logic        res_last, res_last_next;
  status_t     res_status, res_status_next;

  // FAT store, single port.
  logic [7:0]        fat_mem [FAT_BYTES];
  logic              mem_we;
  logic [FAT_AW-1:0] mem_addr;
  logic [7:0]        mem_rdata;

  // Output register load.
  logic        out_free;
  logic        load;
  logic [15:0] ld_sector;
  logic [9:0]  ld_chunk;
  logic [15:0] ld_offset;
  logic        ld_last;
  status_t     ld_status;

  // Step arithmetic.
  logic [9:0]  st_chunk;
  logic [15:0] st_rem;
  logic [7:0]  st_sic;
  logic [13:0] st_pos;
  logic [7:0]  b1_low;
  logic [11:0] nx;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fat_mem[mem_addr] <= cmd.data;
    end
    mem_rdata <= fat_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_start <= DATA_START_RESET;
      spc        <= SPC_RESET;
      ccount     <= CCOUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DATA_START: data_start <= cfg_data;
        REG_SPC:        spc        <= cfg_data[7:0];
        REG_CCOUNT:     ccount     <= cfg_data[11:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      active    <= 1'b0;
      cur       <= '0;
      sic       <= '0;
      remaining <= '0;
      woff      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      active    <= active_next;
      cur       <= cur_next;
      sic       <= sic_next;
      remaining <= remaining_next;
      woff      <= woff_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod       <= prod_next;
    sic_old    <= sic_old_next;
    chunk      <= chunk_next;
    offs       <= offs_next;
    need_link  <= need_link_next;
    done       <= done_next;
    pos        <= pos_next;
    link_oob   <= link_oob_next;
    b0         <= b0_next;
    res_sector <= res_sector_next;
    res_last   <= res_last_next;
    res_status <= res_status_next;
    if (load) begin
      out_sector <= ld_sector;
      out_chunk  <= ld_chunk;
      out_offset <= ld_offset;
      out_last   <= ld_last;
      out_status <= ld_status;
    end
  end

  always_comb begin
    st_chunk = (remaining > 16'(SECTOR_BYTES)) ? CHUNK_W'(SECTOR_BYTES) : remaining[9:0];
    st_rem   = remaining - {6'd0, st_chunk};
    st_sic   = sic + 8'd1;
    st_pos   = {2'b00, cur} + {3'b000, cur[11:1]};
    b1_low   = mem_rdata & NIBBLE_MASK;
    // Odd clusters take the high nibble of the first byte, even ones the low nibble
    // of the second byte as their top bits.
    if (cur[0]) begin
      nx = ({4'd0, b0[7:4]} | {mem_rdata, 4'd0}) & LINK_MASK;
    end else begin
      nx = ({4'd0, b0} | {b1_low[3:0], 8'd0}) & LINK_MASK;
    end
  end

  always_comb begin
    state_next      = state;
    active_next     = active;
    cur_next        = cur;
    sic_next        = sic;
    remaining_next  = remaining;
    woff_next       = woff;
    prod_next       = prod;
    sic_old_next    = sic_old;
    chunk_next      = chunk;
    offs_next       = offs;
    need_link_next  = need_link;
    done_next       = done;
    pos_next        = pos;
    link_oob_next   = link_oob;
    b0_next         = b0;
    res_sector_next = res_sector;
    res_last_next   = res_last;
    res_status_next = res_status;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = st_pos[FAT_AW-1:0];
    load      = 1'b0;
    ld_sector = '0;
    ld_chunk  = '0;
    ld_offset = '0;
    ld_last   = 1'b0;
    ld_status = ST_OK;

    unique case (state)
      B_IDLE: begin
        cmd_pop = cmd_valid && out_free;
        if (cmd_pop) begin
          unique case (cmd.kind)
            CMD_WRITE: begin
              mem_addr = cmd.addr[FAT_AW-1:0];
              mem_we   = (32'(cmd.addr) < FAT_BYTES);
              load     = 1'b1;
            end
            CMD_START: begin
              load        = 1'b1;
              active_next = 1'b0;
              if (cmd.len == '0) begin
                ld_last   = 1'b1;
                ld_status = ST_EMPTY;
              end else if (!cluster_ok(cmd.cluster, ccount)) begin
                ld_last   = 1'b1;
                ld_status = ST_BAD_START;
              end else begin
                cur_next       = cmd.cluster;
                sic_next       = '0;
                remaining_next = cmd.len;
                woff_next      = '0;
                active_next    = 1'b1;
              end
            end
            CMD_STEP: begin
              if (active) begin
                prod_next      = 16'({8'd0, (cur - 12'd2) & LINK_MASK} * {12'd0, spc});
                sic_old_next   = sic;
                chunk_next     = st_chunk;
                offs_next      = woff;
                woff_next      = woff + {6'd0, st_chunk};
                remaining_next = st_rem;
                sic_next       = st_sic;
                done_next      = (st_rem == '0);
                need_link_next = (st_rem != '0) && ((spc == '0) || (st_sic >= spc));
                active_next    = (st_rem != '0);
                pos_next       = st_pos;
                link_oob_next  = (32'(st_pos) + 1 >= FAT_BYTES);
                state_next     = B_SECT;
              end else begin
                load      = 1'b1;
                ld_status = ST_IDLE;
              end
            end
            default: begin
              load      = 1'b1;
              ld_status = ST_IDLE;
            end
          endcase
        end
      end
      B_SECT: begin
        // The first FAT byte of the link arrives now; fetch the second one.
        b0_next         = mem_rdata;
        mem_addr        = FAT_AW'(pos + 14'd1);
        res_sector_next = data_start + prod + {8'd0, sic_old};
        res_last_next   = done;
        res_status_next = ST_OK;
        state_next      = need_link ? B_LINK : B_EMIT;
      end
      B_LINK: begin
        if (link_oob || nx == LINK_BAD) begin
          res_status_next = ST_BAD_CLUSTER;
        end else if (nx >= LINK_EOC) begin
          res_status_next = ST_EARLY_END;
        end else if (!cluster_ok(nx, ccount)) begin
          res_status_next = ST_RANGE;
        end else begin
          res_status_next = ST_OK;
        end
        if (res_status_next != ST_OK) begin
          res_last_next = 1'b1;
          active_next   = 1'b0;
        end else begin
          cur_next = nx;
          sic_next = '0;
        end
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          ld_sector  = res_sector;
          ld_chunk   = chunk;
          ld_offset  = offs;
          ld_last    = res_last;
          ld_status  = res_status;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/fat12_file_sector_walker_unit.sv -----
// Top level of the FAT12 file sector walker: front decoder, command queue, back end.
// Depends on fsw_pkg, fsw_front, fsw_queue, fsw_back and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | opcode, fat_address, fat_byte,
//          |           |                        | start_cluster, file_size, max_bytes
//  out     | output    | out_valid / out_stall  | sector_number, chunk_bytes,
//          |           |                        | buffer_offset, last, status
//  cfg     | input     | cfg_write              | cfg_index, cfg_data
//
// A write, start or idle word is handled in the idle state; a step passes the idle,
// sector and emit states, plus a link state when it crosses a cluster end, since
// the two link bytes come one after the other from the single-port FAT store.
// Reset is synchronous; the FAT store is not cleared and needs no clearing pass.
// in_stall rises when the two-entry queue is full; out_stall holds the result word.
`include "assert_macros.svh"

module fat12_file_sector_walker_unit import fsw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [12:0] fat_address,
  input  logic [7:0]  fat_byte,
  input  logic [11:0] start_cluster,
  input  logic [31:0] file_size,
  input  logic [15:0] max_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] sector_number,
  output logic [9:0]  chunk_bytes,
  output logic [15:0] buffer_offset,
  output logic        last,
  output logic [2:0]  status,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    q_nonempty;
  logic    q_full;
  logic    q_pop;
  logic    q_push;
  status_t out_status;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign status   = out_status;

  fsw_front u_front (
    .opcode        (opcode),
    .fat_address   (fat_address),
    .fat_byte      (fat_byte),
    .start_cluster (start_cluster),
    .file_size     (file_size),
    .max_bytes     (max_bytes),
    .cmd           (front_cmd)
  );

  fsw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  fsw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (head_cmd),
    .cmd_valid  (q_nonempty),
    .cmd_pop    (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sector (sector_number),
    .out_chunk  (chunk_bytes),
    .out_offset (buffer_offset),
    .out_last   (last),
    .out_status (out_status)
  );

  // Any error or empty status ends the read.
  `ASSERT_SAME(a_error_is_last, out_valid && out_status != ST_OK && out_status != ST_IDLE, last)
  // A step that does not end the read always moves a whole sector.
  `ASSERT_SAME(a_full_chunk, out_valid && !last && chunk_bytes != '0, chunk_bytes == 10'(SECTOR_BYTES))
  // The back end never pops an empty queue.
  `ASSERT_SAME(a_pop_nonempty, q_pop, q_nonempty)

endmodule
